/* rtl/u8s_pkg.sv */
// shared types, constants and encoding helpers for the utf-8 sanitiser
package u8s_pkg;

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CP_W = 21;

	// lead byte ranges and continuation bounds
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD3_SURR = 8'hED;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;
	localparam logic [7:0] CONT_LO = 8'h80;
	localparam logic [7:0] CONT_HI = 8'hBF;
	localparam logic [7:0] E0_LO = 8'hA0;
	localparam logic [7:0] ED_HI = 8'h9F;
	localparam logic [7:0] F0_LO = 8'h90;
	localparam logic [7:0] F4_HI = 8'h8F;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
	localparam logic [2:0] REPL_LEN = 3'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic run_last;
		logic stream_done;
	} out_item_t;

	// work for the back end: optional replacement, optional code point,
	// optional trailing replacement
	typedef struct packed {
		logic pre_repl;
		logic main_vld;
		logic [CP_W-1:0] main_cp;
		logic post_repl;
		logic last;
	} job_t;

	// number of utf-8 bytes for a code point
	function automatic logic [2:0] cp_len(input logic [CP_W-1:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < 21'h10000) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// byte j of the utf-8 encoding of a code point
	function automatic logic [7:0] cp_byte(input logic [CP_W-1:0] cp, input logic [1:0] j);
		logic [2:0] n;
		logic [7:0] b;
		n = cp_len(cp);
		b = {1'b0, cp[6:0]};
		case (n)
			3'd2: begin
				b = (j == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			end
			3'd3: begin
				case (j)
					2'd0: b = {4'b1110, cp[15:12]};
					2'd1: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				case (j)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = {1'b0, cp[6:0]};
		endcase
		return b;
	endfunction

endpackage

/* rtl/u8s_front.sv */
// front end: decoder state and per-byte classification into jobs
module u8s_front (
	input logic clk,
	input logic arst_n,
	input logic acc_en,
	input u8s_pkg::in_item_t item,
	output logic push,
	output u8s_pkg::job_t job
);
	import u8s_pkg::*;

	logic [CP_W-1:0] acc_q;
	logic [1:0] need_q;
	logic [1:0] seen_q;
	logic [7:0] lo_q;
	logic [7:0] hi_q;

	logic [CP_W-1:0] acc_n;
	logic [1:0] need_n;
	logic [1:0] seen_n;
	logic [7:0] lo_n;
	logic [7:0] hi_n;

	// lead byte handling, always from the idle state
	logic [CP_W-1:0] l_acc;
	logic [1:0] l_need;
	logic [7:0] l_lo;
	logic [7:0] l_hi;
	logic l_main;
	logic [CP_W-1:0] l_cp;

	logic [7:0] b;
	logic [CP_W-1:0] acc_inc;
	logic [1:0] seen_inc;

	assign b = item.in_byte;
	assign acc_inc = {acc_q[CP_W-7:0], b[5:0]};
	assign seen_inc = seen_q + 2'd1;

	always_comb begin
		l_acc = '0;
		l_need = 2'd0;
		l_lo = CONT_LO;
		l_hi = CONT_HI;
		l_main = 1'b0;
		l_cp = '0;
		if (b <= ASCII_MAX) begin
			l_main = 1'b1;
			l_cp = {13'd0, b};
		end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
			l_need = 2'd1;
			l_acc = {16'd0, b[4:0]};
		end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
			l_need = 2'd2;
			l_acc = {17'd0, b[3:0]};
			l_lo = (b == LEAD3_MIN) ? E0_LO : CONT_LO;
			l_hi = (b == LEAD3_SURR) ? ED_HI : CONT_HI;
		end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
			l_need = 2'd3;
			l_acc = {18'd0, b[2:0]};
			l_lo = (b == LEAD4_MIN) ? F0_LO : CONT_LO;
			l_hi = (b == LEAD4_MAX) ? F4_HI : CONT_HI;
		end else begin
			l_main = 1'b1;
			l_cp = REPL_CP;
		end
	end

	always_comb begin
		job = '0;
		job.last = item.stream_end;
		acc_n = acc_q;
		need_n = need_q;
		seen_n = seen_q;
		lo_n = lo_q;
		hi_n = hi_q;
		if (need_q == 2'd0 || b < lo_q || b > hi_q) begin
			// bad continuation ends the sequence, then the byte is a lead
			job.pre_repl = (need_q != 2'd0);
			job.main_vld = l_main;
			job.main_cp = l_cp;
			acc_n = l_acc;
			need_n = l_need;
			seen_n = 2'd0;
			lo_n = l_lo;
			hi_n = l_hi;
		end else begin
			lo_n = CONT_LO;
			hi_n = CONT_HI;
			acc_n = acc_inc;
			seen_n = seen_inc;
			if (seen_inc == need_q) begin
				job.main_vld = 1'b1;
				job.main_cp = acc_inc;
				acc_n = '0;
				need_n = 2'd0;
				seen_n = 2'd0;
			end
		end
		if (item.stream_end) begin
			// unfinished sequence at end of stream
			job.post_repl = (need_n != 2'd0);
			acc_n = '0;
			need_n = 2'd0;
			seen_n = 2'd0;
			lo_n = CONT_LO;
			hi_n = CONT_HI;
		end
	end

	assign push = acc_en && (job.pre_repl || job.main_vld || job.post_repl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			need_q <= 2'd0;
			seen_q <= 2'd0;
			lo_q <= CONT_LO;
			hi_q <= CONT_HI;
		end else if (acc_en) begin
			acc_q <= acc_n;
			need_q <= need_n;
			seen_q <= seen_n;
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
	end

endmodule

/* rtl/u8s_fifo.sv */
// small job queue between front and back
module u8s_fifo #(
	parameter int DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input u8s_pkg::job_t wr_job,
	output logic full,
	input logic pop,
	output logic head_vld,
	output u8s_pkg::job_t head_job
);
	import u8s_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head_job = mem_q[rd_ptr_q];
	assign do_pop = pop && head_vld;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/u8s_back.sv */
// back end: walks a job into the output register one output byte per cycle while res_ready allows
module u8s_back (
	input logic clk,
	input logic arst_n,
	input logic head_vld,
	input u8s_pkg::job_t head_job,
	output logic pop,
	output logic res_valid,
	input logic res_ready,
	output u8s_pkg::out_item_t res_item
);
	import u8s_pkg::*;

	logic [2:0] idx_q;
	logic res_valid_q;
	out_item_t res_item_q;

	logic [2:0] m_len;
	logic [2:0] total;
	logic [2:0] off;
	logic [2:0] j;
	logic [2:0] k;
	logic [7:0] cur_byte;
	logic is_last;
	logic load;

	function automatic logic [7:0] repl_byte(input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0: r = cp_byte(REPL_CP, 2'd0);
			2'd1: r = cp_byte(REPL_CP, 2'd1);
			default: r = cp_byte(REPL_CP, 2'd2);
		endcase
		return r;
	endfunction

	always_comb begin
		m_len = head_job.main_vld ? cp_len(head_job.main_cp) : 3'd0;
		off = head_job.pre_repl ? REPL_LEN : 3'd0;
		total = off + m_len + (head_job.post_repl ? REPL_LEN : 3'd0);
		j = idx_q - off;
		k = j - m_len;
		if (head_job.pre_repl && idx_q < REPL_LEN) begin
			cur_byte = repl_byte(idx_q[1:0]);
		end else if (j < m_len) begin
			cur_byte = cp_byte(head_job.main_cp, j[1:0]);
		end else begin
			cur_byte = repl_byte(k[1:0]);
		end
		is_last = (idx_q == total - 3'd1);
	end

	assign load = head_vld && (!res_valid_q || res_ready);
	assign pop = load && is_last;
	assign res_valid = res_valid_q;
	assign res_item = res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_item_q.out_byte <= cur_byte;
			res_item_q.run_last <= is_last;
			res_item_q.stream_done <= is_last && head_job.last;
		end
	end

endmodule

/* rtl/utf8_validating_sanitizer.sv */
// utf-8 validating sanitiser, byte in, byte out, replacement-character repair
// Byte-serial UTF-8 repair after the WHATWG decoder. Each transaction on the
// byte channel carries one raw byte and an end-of-stream flag; each transaction
// on the result channel carries one byte of well-formed UTF-8, with run_last on
// the final byte caused by an input byte and stream_done on the final byte of
// the stream. Invalid or truncated sequences become U+FFFD (EF BF BD); a byte
// that breaks a sequence is then decoded again as a lead byte. An input byte
// yielding k output bytes (k from 0 to 6) puts them in turn on the single
// output byte lane, so plain ASCII or complete sequences run at one byte per
// cycle in steady state while res_ready holds; a byte yielding nothing uses
// the input side only. An accepted byte's job is queued, then its first result
// byte is loaded into the output register. A queue of QUEUE_DEPTH jobs between
// decoder and sequencer: multi-byte bursts stall the input only once it fills.
module utf8_validating_sanitizer #(
	parameter int QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_ready,
	input u8s_pkg::in_item_t byte_item,
	output logic res_valid,
	input logic res_ready,
	output u8s_pkg::out_item_t res_item
);
	import u8s_pkg::*;

	// jobs from the decoder towards the sequencer
	logic push;
	job_t push_job;
	logic q_full;
	logic head_vld;
	job_t head_job;
	logic pop;
	logic acc_en;

	// a transaction is taken whenever the queue has room, even with empty jobs
	assign byte_ready = !q_full;
	assign acc_en = byte_valid && byte_ready;

	// decoder state and classification
	u8s_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.acc_en(acc_en),
		.item(byte_item),
		.push(push),
		.job(push_job)
	);

	// decoupling queue
	u8s_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(push_job),
		.full(q_full),
		.pop(pop),
		.head_vld(head_vld),
		.head_job(head_job)
	);

	// byte sequencer and output register
	u8s_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_vld(head_vld),
		.head_job(head_job),
		.pop(pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item)
	);

endmodule

/* rtl/u8s_checker.sv */
// port-level checks for the utf-8 sanitiser and their binding
module u8s_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input u8s_pkg::out_item_t res_item
);
	import u8s_pkg::*;

	// stalled result transaction holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// end of stream is always the last byte of its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res_item.stream_done || res_item.run_last))
		else $error("stream_done without run_last");

	// bytes that never occur in well-formed utf-8
	a_legal_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.out_byte != 8'hC0 && res_item.out_byte != 8'hC1
			&& res_item.out_byte < 8'hF5))
		else $error("illegal utf-8 byte on output");

	// a run never ends on a lead byte
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.run_last |-> (res_item.out_byte[7:6] != 2'b11))
		else $error("run ends inside a sequence");

endmodule

bind utf8_validating_sanitizer u8s_checker u_u8s_checker (.*);
